### hw/rtl/pctd_pkg.sv
// Shared types and constants for the prefix code trie decoder.
package pctd_pkg;

    localparam int NODE_COUNT   = 1024;
    localparam int NODE_AW      = $clog2(NODE_COUNT);
    localparam int CNT_W        = NODE_AW + 1;
    localparam int SYM_W        = 9;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int MAX_CODE_LEN = 32;
    localparam int BPOS_W       = $clog2(CODE_W);
    localparam int STATUS_W     = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_BADPATH  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [NODE_AW-1:0] kid1;
        logic [NODE_AW-1:0] kid0;
        logic               leaf;
        logic [SYM_W-1:0]   sym;
    } node_t;

    typedef struct packed {
        logic               rd_en;
        logic [NODE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [NODE_AW-1:0] wr_addr;
        node_t              wr_data;
    } store_req_t;

endpackage

### hw/rtl/pctd_in_if.sv
// Input channel carrying insert and decode transactions.
interface pctd_in_if
    import pctd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [SYM_W-1:0]  symbol_in;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
    logic              bit_in;

    modport source (
        output valid, action, symbol_in, code_value, code_length, bit_in,
        input  ready
    );
    modport sink (
        input  valid, action, symbol_in, code_value, code_length, bit_in,
        output ready
    );
endinterface

### hw/rtl/pctd_out_if.sv
// Output channel carrying one result transaction per input transaction.
interface pctd_out_if
    import pctd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                symbol_valid;
    logic [SYM_W-1:0]    symbol_out;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, symbol_valid, symbol_out, status,
        input  ready
    );
    modport sink (
        input  valid, symbol_valid, symbol_out, status,
        output ready
    );
endinterface

### hw/rtl/prefix_code_trie_decoder_unit.sv
// Top level of the prefix code trie decoder: sequencer around the node memory.
//
// One transaction at a time. A decode goes through accept, read of the
// current node, read of the selected child to test for a leaf, and the
// result; a missing branch skips the child read. An insert reads d + 1
// nodes on the existing path, writes the link into the last of them and
// then writes k new nodes one per cycle; a zero length goes straight to the
// result and a conflict or full store ends after the walk. The steps follow
// from the single node memory and its registered read. The next
// transaction is accepted while a result waits in the output register; the
// memory needs no clearing after reset.
module prefix_code_trie_decoder_unit
    import pctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pctd_in_if.sink    item,
    pctd_out_if.source result
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_IWALK  = 7'b0000010,
        S_ILINK  = 7'b0000100,
        S_IFRESH = 7'b0001000,
        S_DWALK  = 7'b0010000,
        S_DLEAF  = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [NODE_AW-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [BPOS_W-1:0]   bpos_reg, bpos_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                bit_reg, bit_next;
    logic [NODE_AW-1:0]  nx_reg, nx_next;
    logic [NODE_AW-1:0]  walk_reg, walk_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    node_t               link_reg, link_next;
    logic                res_valid_reg, res_valid_next;
    logic [SYM_W-1:0]    res_sym_reg, res_sym_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_symv_reg, out_symv_next;
    logic [SYM_W-1:0]    out_sym_reg, out_sym_next;
    status_t             out_status_reg, out_status_next;

    store_req_t          req;
    node_t               rd_node;

    logic                item_acc;
    logic                out_free;
    logic [LEN_W-1:0]    len_c;
    logic                walk_bit;
    logic [NODE_AW-1:0]  walk_nx;
    logic                dec_bit_sel;
    logic [NODE_AW-1:0]  dec_nx;
    logic [CNT_W:0]      need;
    logic [NODE_AW-1:0]  fresh;
    logic [NODE_AW-1:0]  fresh_nx;
    logic                next_bit;

    pctd_node_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_node (rd_node)
    );

    assign item.ready    = (state_reg == S_IDLE);
    assign item_acc      = item.valid && item.ready;
    assign out_free      = !out_valid_reg || result.ready;

    assign result.valid        = out_valid_reg;
    assign result.symbol_valid = out_symv_reg;
    assign result.symbol_out   = out_sym_reg;
    assign result.status       = out_status_reg;

    assign len_c = (item.code_length > LEN_W'(MAX_CODE_LEN)) ?
                   LEN_W'(MAX_CODE_LEN) : item.code_length;

    assign walk_bit    = code_reg[bpos_reg];
    assign walk_nx     = walk_bit ? rd_node.kid1 : rd_node.kid0;
    assign dec_bit_sel = bit_reg;
    assign dec_nx      = dec_bit_sel ? rd_node.kid1 : rd_node.kid0;
    assign need        = {1'b0, used_reg} + (CNT_W+1)'(rem_reg);
    assign fresh       = used_reg[NODE_AW-1:0];
    assign fresh_nx    = fresh + NODE_AW'(1);
    assign next_bit    = code_reg[bpos_reg - BPOS_W'(1)];

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        bpos_next       = bpos_reg;
        code_next       = code_reg;
        sym_next        = sym_reg;
        bit_next        = bit_reg;
        nx_next         = nx_reg;
        walk_next       = walk_reg;
        used_next       = used_reg;
        link_next       = link_reg;
        res_valid_next  = res_valid_reg;
        res_sym_next    = res_sym_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_symv_next   = out_symv_reg;
        out_sym_next    = out_sym_reg;
        out_status_next = out_status_reg;
        req             = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    res_valid_next  = 1'b0;
                    res_sym_next    = '0;
                    res_status_next = ST_OK;
                    if (item.action == ACT_DECODE)
                    begin
                        bit_next    = item.bit_in;
                        req.rd_en   = 1'b1;
                        req.rd_addr = walk_reg;
                        state_next  = S_DWALK;
                    end
                    else if (item.code_length == '0)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        code_next   = item.code_value;
                        sym_next    = item.symbol_in;
                        rem_next    = len_c;
                        bpos_next   = BPOS_W'(len_c - LEN_W'(1));
                        cur_next    = '0;
                        req.rd_en   = 1'b1;
                        req.rd_addr = '0;
                        state_next  = S_IWALK;
                    end
                end
            end
            S_IWALK:
            begin
                if (rd_node.leaf)
                begin
                    res_status_next = ST_CONFLICT;
                    state_next      = S_RESULT;
                end
                else if (walk_nx == '0)
                begin
                    link_next = rd_node;
                    if (need > (CNT_W+1)'(NODE_COUNT))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_ILINK;
                    end
                end
                else if (rem_reg == LEN_W'(1))
                begin
                    res_status_next = ST_CONFLICT;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cur_next    = walk_nx;
                    rem_next    = rem_reg - LEN_W'(1);
                    bpos_next   = bpos_reg - BPOS_W'(1);
                    req.rd_en   = 1'b1;
                    req.rd_addr = walk_nx;
                end
            end
            S_ILINK:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_reg;
                req.wr_data = link_reg;
                if (walk_bit)
                begin
                    req.wr_data.kid1 = fresh;
                end
                else
                begin
                    req.wr_data.kid0 = fresh;
                end
                state_next = S_IFRESH;
            end
            S_IFRESH:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = fresh;
                req.wr_data = '0;
                used_next   = used_reg + CNT_W'(1);
                if (rem_reg == LEN_W'(1))
                begin
                    req.wr_data.leaf = 1'b1;
                    req.wr_data.sym  = sym_reg;
                    state_next       = S_RESULT;
                end
                else
                begin
                    if (next_bit)
                    begin
                        req.wr_data.kid1 = fresh_nx;
                    end
                    else
                    begin
                        req.wr_data.kid0 = fresh_nx;
                    end
                    rem_next  = rem_reg - LEN_W'(1);
                    bpos_next = bpos_reg - BPOS_W'(1);
                end
            end
            S_DWALK:
            begin
                if (dec_nx == '0)
                begin
                    res_status_next = ST_BADPATH;
                    walk_next       = '0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    nx_next     = dec_nx;
                    req.rd_en   = 1'b1;
                    req.rd_addr = dec_nx;
                    state_next  = S_DLEAF;
                end
            end
            S_DLEAF:
            begin
                if (rd_node.leaf)
                begin
                    res_valid_next = 1'b1;
                    res_sym_next   = rd_node.sym;
                    walk_next      = '0;
                end
                else
                begin
                    walk_next = nx_reg;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_symv_next   = res_valid_reg;
                    out_sym_next    = res_sym_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_reg      <= '0;
            used_reg      <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        bpos_reg       <= bpos_next;
        code_reg       <= code_next;
        sym_reg        <= sym_next;
        bit_reg        <= bit_next;
        nx_reg         <= nx_next;
        link_reg       <= link_next;
        res_valid_reg  <= res_valid_next;
        res_sym_reg    <= res_sym_next;
        res_status_reg <= res_status_next;
        out_symv_reg   <= out_symv_next;
        out_sym_reg    <= out_sym_next;
        out_status_reg <= out_status_next;
    end

endmodule

### hw/rtl/pctd_node_store.sv
// Trie node memory with registered read and a cleared root after reset.
module pctd_node_store
    import pctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output node_t      rd_node
);

    node_t mem [NODE_COUNT];
    node_t rdata_reg;
    logic  root_valid_reg;
    logic  rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
        end
        else
        begin
            if (req.wr_en && (req.wr_addr == '0))
            begin
                root_valid_reg <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_zero_reg <= (req.rd_addr == '0) && !root_valid_reg;
            end
        end
    end

    assign rd_node = rd_zero_reg ? node_t'('0) : rdata_reg;

endmodule

### test/tb.sv
// Self-checking testbench for the prefix code trie decoder.
module tb;
    import pctd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        logic              action;
        logic [SYM_W-1:0]  symbol_in;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
        logic              bit_in;
    } trie_op_t;

    typedef struct {
        logic             symbol_valid;
        logic [SYM_W-1:0] symbol;
        status_t          status;
    } trie_res_t;

    logic clk;
    logic rst_n;

    pctd_in_if  item_if ();
    pctd_out_if result_if ();

    prefix_code_trie_decoder_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    logic [NODE_AW-1:0] kid0_tbl [NODE_COUNT];
    logic [NODE_AW-1:0] kid1_tbl [NODE_COUNT];
    logic               leaf_tbl [NODE_COUNT];
    logic [SYM_W-1:0]   sym_tbl  [NODE_COUNT];
    int                 alloc_count;
    int                 walk_node;

    trie_op_t    pending_q [$];
    trie_res_t   result_q [$];
    logic [CODE_W-1:0] tried_code [$];
    int          tried_len [$];

    trie_op_t    op_seen;
    trie_op_t    op_next;
    trie_res_t   res_exp;
    int          cycle_cnt;
    int          accepted;
    int          stim_items;
    int          mismatches;
    int          inserts_done;
    int          decodes_done;
    int          symbols_out;
    int          status_seen [4];
    logic        calm;

    assign calm = (accepted >= 600) && (accepted < 900);

    always #4 clk = ~clk;

    function automatic trie_res_t trie_step(input trie_op_t op);
        trie_res_t r;
        int        n;
        int        d;
        int        cur;
        int        nx;
        logic      hit_leaf;
        logic      missing;
        r.symbol_valid = 1'b0;
        r.symbol       = '0;
        r.status       = ST_OK;
        if (op.action == ACT_DECODE)
        begin
            nx = op.bit_in ? kid1_tbl[walk_node] : kid0_tbl[walk_node];
            if (nx == 0)
            begin
                r.status  = ST_BADPATH;
                walk_node = 0;
            end
            else if (leaf_tbl[nx])
            begin
                r.symbol_valid = 1'b1;
                r.symbol       = sym_tbl[nx];
                walk_node      = 0;
            end
            else
            begin
                walk_node = nx;
            end
        end
        else if (op.code_length != 0)
        begin
            n        = (op.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : op.code_length;
            cur      = 0;
            d        = 0;
            hit_leaf = 1'b0;
            missing  = 1'b0;
            while (d < n && !hit_leaf && !missing)
            begin
                if (leaf_tbl[cur])
                begin
                    hit_leaf = 1'b1;
                end
                else
                begin
                    nx = op.code_value[n-1-d] ? kid1_tbl[cur] : kid0_tbl[cur];
                    if (nx == 0)
                    begin
                        missing = 1'b1;
                    end
                    else
                    begin
                        cur = nx;
                        d++;
                    end
                end
            end
            if (hit_leaf || !missing)
            begin
                r.status = ST_CONFLICT;
            end
            else if (alloc_count + n - d > NODE_COUNT)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                while (d < n)
                begin
                    kid0_tbl[alloc_count] = '0;
                    kid1_tbl[alloc_count] = '0;
                    leaf_tbl[alloc_count] = 1'b0;
                    sym_tbl[alloc_count]  = '0;
                    if (op.code_value[n-1-d])
                        kid1_tbl[cur] = NODE_AW'(alloc_count);
                    else
                        kid0_tbl[cur] = NODE_AW'(alloc_count);
                    cur = alloc_count;
                    alloc_count++;
                    d++;
                end
                leaf_tbl[cur] = 1'b1;
                sym_tbl[cur]  = op.symbol_in;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 60)
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        mismatches++;
    endtask

    task automatic queue_insert(input logic [SYM_W-1:0] s, input logic [CODE_W-1:0] c,
                                input logic [LEN_W-1:0] l);
        trie_op_t op;
        op.action      = ACT_INSERT;
        op.symbol_in   = s;
        op.code_value  = c;
        op.code_length = l;
        op.bit_in      = 1'($urandom_range(0, 1));
        pending_q.insert(pending_q.size(), op);
        if (l != 0)
        begin
            tried_code.insert(tried_code.size(), c);
            tried_len.insert(tried_len.size(),
                             (l > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(l));
            stim_items++;
        end
    endtask

    task automatic queue_decode(input logic b);
        trie_op_t op;
        op.action      = ACT_DECODE;
        op.symbol_in   = SYM_W'($urandom);
        op.code_value  = $urandom;
        op.code_length = LEN_W'($urandom_range(0, 63));
        op.bit_in      = b;
        pending_q.insert(pending_q.size(), op);
        stim_items++;
    endtask

    task automatic queue_code_bits(input int idx, input int upto);
        int i;
        for (i = 0; i < upto; i++)
            queue_decode(tried_code[idx][tried_len[idx]-1-i]);
    endtask

    task automatic queue_random_insert(input logic force_long);
        int                len;
        int                n;
        int                r;
        logic [CODE_W-1:0] c;
        r   = $urandom_range(0, 99);
        len = force_long ? MAX_CODE_LEN :
              (r < 80) ? $urandom_range(1, 10) :
              (r < 95) ? $urandom_range(11, 32) : $urandom_range(33, 63);
        n   = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
        c   = $urandom;
        if (n >= 4 && $urandom_range(0, 3) != 0)
            c[n-1 -: 3] = 3'b111;
        queue_insert(SYM_W'($urandom_range(0, 511)), c, LEN_W'(len));
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || item_if.valid || result_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_random_mix(input int count);
        int pick;
        int idx;
        int k;
        while (stim_items < count)
        begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, tried_len.size() - 1);
            if (pick < 2)
            begin
                queue_insert(SYM_W'($urandom), $urandom, '0);
            end
            else if (pick < 25)
            begin
                queue_random_insert(1'b0);
            end
            else if (pick < 80)
            begin
                queue_code_bits(idx, tried_len[idx]);
            end
            else if (pick < 90)
            begin
                k = $urandom_range(0, tried_len[idx] - 1);
                queue_code_bits(idx, k);
                queue_decode(~tried_code[idx][tried_len[idx]-1-k]);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) queue_decode(1'($urandom_range(0, 1)));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid       <= 1'b0;
            item_if.action      <= ACT_INSERT;
            item_if.symbol_in   <= '0;
            item_if.code_value  <= '0;
            item_if.code_length <= '0;
            item_if.bit_in      <= 1'b0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
            begin
                op_seen.action      = item_if.action;
                op_seen.symbol_in   = item_if.symbol_in;
                op_seen.code_value  = item_if.code_value;
                op_seen.code_length = item_if.code_length;
                op_seen.bit_in      = item_if.bit_in;
                result_q.insert(result_q.size(), trie_step(op_seen));
                if (op_seen.action == ACT_INSERT)
                    inserts_done++;
                else
                    decodes_done++;
                accepted++;
            end
            if (!item_if.valid || item_if.ready)
            begin
                if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20))
                begin
                    op_next = pending_q.pop_front();
                    item_if.valid       <= 1'b1;
                    item_if.action      <= op_next.action;
                    item_if.symbol_in   <= op_next.symbol_in;
                    item_if.code_value  <= op_next.code_value;
                    item_if.code_length <= op_next.code_length;
                    item_if.bit_in      <= op_next.bit_in;
                end
                else
                begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("result with no transaction pending");
                end
                else
                begin
                    res_exp = result_q.pop_front();
                    if (result_if.symbol_valid !== res_exp.symbol_valid)
                        report_mismatch($sformatf("symbol_valid %b, expected %b",
                                        result_if.symbol_valid, res_exp.symbol_valid));
                    if (result_if.symbol_out !== res_exp.symbol)
                        report_mismatch($sformatf("symbol_out %0d, expected %0d",
                                        result_if.symbol_out, res_exp.symbol));
                    if (result_if.status !== res_exp.status)
                        report_mismatch($sformatf("status %b, expected %s",
                                        result_if.status, res_exp.status.name()));
                    status_seen[res_exp.status]++;
                    if (res_exp.symbol_valid)
                        symbols_out++;
                end
            end
            result_if.ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        item_if.valid       = 1'b0;
        item_if.action      = ACT_INSERT;
        item_if.symbol_in   = '0;
        item_if.code_value  = '0;
        item_if.code_length = '0;
        item_if.bit_in      = 1'b0;
        result_if.ready     = 1'b0;
        cycle_cnt           = 0;
        accepted            = 0;
        stim_items          = 0;
        mismatches          = 0;
        inserts_done        = 0;
        decodes_done        = 0;
        symbols_out         = 0;
        status_seen         = '{default: 0};
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            kid0_tbl[i] = '0;
            kid1_tbl[i] = '0;
            leaf_tbl[i] = 1'b0;
            sym_tbl[i]  = '0;
        end
        alloc_count = 1;
        walk_node   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_decode(1'b0);
        queue_decode(1'b1);
        queue_insert(9'd5, 32'hFFFF_FFFF, 6'd0);
        queue_insert(9'd0, 32'h0000_0000, 6'd1);
        queue_insert(9'd258, 32'h0000_0002, 6'd2);
        queue_insert(9'd511, 32'h0000_0006, 6'd3);
        queue_insert(9'd3, 32'hFFFF_FFFE, 6'd1);
        queue_insert(9'd4, 32'h0000_0001, 6'd2);
        queue_insert(9'd7, 32'h0000_0001, 6'd1);
        queue_insert(9'h155, 32'hFFFF_FFFF, 6'd40);
        queue_insert(9'h0AA, 32'hE000_0000, 6'd63);
        queue_decode(1'b0);
        queue_decode(1'b1);
        queue_decode(1'b0);
        queue_decode(1'b1);
        queue_decode(1'b1);
        queue_decode(1'b0);
        queue_decode(1'b1);
        queue_decode(1'b1);
        queue_decode(1'b1);
        queue_decode(1'b0);
        queue_decode(1'b1);
        wait_drained();

        queue_random_mix(RANDOM_ITEMS);
        wait_drained();

        repeat (40) queue_random_insert(1'b1);
        repeat (10) queue_random_insert(1'b0);
        queue_random_mix(RANDOM_ITEMS + 250);
        wait_drained();

        repeat (20) @(negedge clk);
        $display("run covered %0d inserts and %0d decode bits, %0d symbols decoded",
                 inserts_done, decodes_done, symbols_out);
        $display("nodes used %0d; status counts: ok %0d, conflict %0d, bad path %0d, full %0d",
                 alloc_count, status_seen[ST_OK], status_seen[ST_CONFLICT],
                 status_seen[ST_BADPATH], status_seen[ST_FULL]);
        if (mismatches == 0 && result_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
hw/rtl/pctd_pkg.sv
hw/rtl/pctd_in_if.sv
hw/rtl/pctd_out_if.sv
hw/rtl/pctd_node_store.sv
hw/rtl/prefix_code_trie_decoder_unit.sv
test/tb.sv
